@@ rtl/rti_pkg.sv @@
// Shared types and constants for the ray/triangle intersection core.
package rti_pkg;

  localparam int DIST_W = 31;
  localparam int CTL_W  = 16;
  localparam int REASON_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [CTL_W-1:0] EPS_RESET      = 16'd7;
  localparam logic [CTL_W-1:0] MIN_DIST_RESET = 16'd66;

  localparam logic [REASON_W-1:0] MISS_NONE     = 3'd0;
  localparam logic [REASON_W-1:0] MISS_PARALLEL = 3'd1;
  localparam logic [REASON_W-1:0] MISS_NEAR     = 3'd2;
  localparam logic [REASON_W-1:0] MISS_GAMMA    = 3'd3;
  localparam logic [REASON_W-1:0] MISS_BETA     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_EPS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 3'd7;

  // Control that travels with each beat through the divider stages.
  typedef struct packed {
    logic                valid;
    logic [REASON_W-1:0] reason;
    logic                sat;
  } rti_meta_t;

endpackage

@@ rtl/rti_if.sv @@
// Valid/ready channel interfaces for triangles in and test results out.
interface rti_tri_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vert_a_x;
  logic signed [COORD_WIDTH-1:0] vert_a_y;
  logic signed [COORD_WIDTH-1:0] vert_a_z;
  logic signed [COORD_WIDTH-1:0] vert_b_x;
  logic signed [COORD_WIDTH-1:0] vert_b_y;
  logic signed [COORD_WIDTH-1:0] vert_b_z;
  logic signed [COORD_WIDTH-1:0] vert_c_x;
  logic signed [COORD_WIDTH-1:0] vert_c_y;
  logic signed [COORD_WIDTH-1:0] vert_c_z;

  modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                  vert_c_x, vert_c_y, vert_c_z, input ready);
  modport sink (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

interface rti_res_if;
  import rti_pkg::*;
  logic                valid;
  logic                ready;
  logic                hit;
  logic [DIST_W-1:0]   hit_distance;
  logic [REASON_W-1:0] miss_reason;

  modport source (output valid, hit, hit_distance, miss_reason, input ready);
  modport sink (input valid, hit, hit_distance, miss_reason, output ready);
endinterface

@@ rtl/rti_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, distance in Q.F units.
module rti_div #(
  parameter int RW = 119,
  parameter int DW = 88
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  rti_pkg::rti_meta_t  in_meta,
  input  logic [RW-1:0]       in_lhs,
  input  logic [DW-1:0]       in_det,
  output rti_pkg::rti_meta_t  out_meta,
  output logic [rti_pkg::DIST_W-1:0] out_quo
);
  import rti_pkg::*;

  logic [RW-1:0]     rem_r  [1:DIST_W];
  logic [DW-1:0]     den_r  [1:DIST_W];
  logic [DIST_W-1:0] quo_r  [1:DIST_W];
  rti_meta_t         meta_r [1:DIST_W];

  logic [RW-1:0]     rem_s  [0:DIST_W-1];
  logic [DW-1:0]     den_s  [0:DIST_W-1];
  logic [DIST_W-1:0] quo_s  [0:DIST_W-1];
  rti_meta_t         meta_s [0:DIST_W-1];

  assign rem_s[0]  = in_lhs;
  assign den_s[0]  = in_det;
  assign quo_s[0]  = '0;
  assign meta_s[0] = in_meta;

  for (genvar k = 1; k < DIST_W; k++) begin : g_tap
    assign rem_s[k]  = rem_r[k];
    assign den_s[k]  = den_r[k];
    assign quo_s[k]  = quo_r[k];
    assign meta_s[k] = meta_r[k];
  end

  for (genvar k = 0; k < DIST_W; k++) begin : g_stage
    localparam int B = DIST_W - 1 - k;
    logic [RW-1:0] part;
    logic          ge;

    assign part = RW'(den_s[k]) << B;
    assign ge   = (rem_s[k] >= part);

    always_ff @(posedge clk) begin
      if (adv) begin
        meta_r[k+1].reason <= meta_s[k].reason;
        meta_r[k+1].sat    <= meta_s[k].sat;
        den_r[k+1]         <= den_s[k];
        rem_r[k+1]         <= ge ? (rem_s[k] - part) : rem_s[k];
        quo_r[k+1]         <= quo_s[k] | (DIST_W'(ge) << B);
      end
      if (!rst_n) begin
        meta_r[k+1].valid <= 1'b0;
      end else if (adv) begin
        meta_r[k+1].valid <= meta_s[k].valid;
      end
    end
  end

  assign out_meta = meta_r[DIST_W];
  assign out_quo  = quo_r[DIST_W];

endmodule

@@ rtl/ray_triangle_intersect_core.sv @@
// Ray/triangle intersection core: Cramer's rule datapath with pipelined distance divide.
//
//  channel   dir  handshake              carries
//  in_tri    in   valid/ready            vertices A, B, C (signed Q.F)
//  out_res   out  valid/ready            hit, hit_distance, miss_reason
//  cfg_*     in   write enable, no wait  ray origin, direction, epsilon, min distance
//
// Takes one triangle per cycle unless the output is held; the pipe is ten arithmetic stages,
// one stage per quotient bit of the 31-bit distance divider, and the output register.
// Reset clears all valid bits and loads the register defaults.
// A beat waiting at the output freezes the whole pipe; nothing moves until it is taken.
module ray_triangle_intersect_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  rti_tri_if.sink   in_tri,
  rti_res_if.source out_res,
  input  logic                                   cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [((COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2)-1:0] cfg_data
);
  import rti_pkg::*;

  localparam int EW   = COORD_WIDTH + 1;
  localparam int DRW  = FRAC_BITS + 2;
  localparam int PMW  = EW + DRW;
  localparam int MW   = PMW + 1;
  localparam int PNW  = 2 * EW;
  localparam int NW   = PNW + 1;
  localparam int DW   = EW + MW + 2;
  localparam int TW   = EW + NW + 2;
  localparam int ML   = MW / 2;
  localparam int MH   = MW - ML;
  localparam int NL   = NW / 2;
  localparam int NH   = NW - NL;
  localparam int PDLW = EW + ML + 1;
  localparam int PDHW = EW + MH;
  localparam int PNLW = EW + NL + 1;
  localparam int PNHW = EW + NH;
  localparam int PGLW = DRW + NL + 1;
  localparam int PGHW = DRW + NH;
  localparam int PDW  = DW + 1;
  localparam int PTW  = TW + 1;
  localparam int DL   = PDW / 2;
  localparam int DH   = PDW - DL;
  localparam int MLW  = CTL_W + DL + 2;
  localparam int MHW  = CTL_W + 1 + DH;
  localparam int EPW  = PDW + CTL_W + 2 * FRAC_BITS;
  localparam int RW   = ((PTW + FRAC_BITS > PDW + DIST_W) ? PTW + FRAC_BITS : PDW + DIST_W) + 1;
  localparam int NSTG = 10;

  // configuration registers
  logic signed [COORD_WIDTH-1:0] origin_r [3];
  logic signed [DRW-1:0]         dir_r    [3];
  logic [CTL_W-1:0]              eps_r;
  logic [CTL_W-1:0]              mind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
      dir_r[0]    <= '0;
      dir_r[1]    <= '0;
      dir_r[2]    <= DRW'(1) << FRAC_BITS;
      eps_r       <= EPS_RESET;
      mind_r      <= MIN_DIST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_r[0] <= cfg_data[COORD_WIDTH-1:0];
        CFG_ORIGIN_Y: origin_r[1] <= cfg_data[COORD_WIDTH-1:0];
        CFG_ORIGIN_Z: origin_r[2] <= cfg_data[COORD_WIDTH-1:0];
        CFG_DIR_X:    dir_r[0]    <= cfg_data[DRW-1:0];
        CFG_DIR_Y:    dir_r[1]    <= cfg_data[DRW-1:0];
        CFG_DIR_Z:    dir_r[2]    <= cfg_data[DRW-1:0];
        CFG_DET_EPS:  eps_r       <= cfg_data[CTL_W-1:0];
        CFG_MIN_DIST: mind_r      <= cfg_data[CTL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe control: the whole pipe advances unless the output beat is held
  logic adv;
  logic out_valid_r;
  logic [NSTG:1] v_r;

  assign adv          = !out_valid_r || out_res.ready;
  assign in_tri.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-1:1], in_tri.valid};
    end
  end

  logic signed [COORD_WIDTH-1:0] va [3];
  logic signed [COORD_WIDTH-1:0] vb [3];
  logic signed [COORD_WIDTH-1:0] vc [3];

  assign va[0] = in_tri.vert_a_x;
  assign va[1] = in_tri.vert_a_y;
  assign va[2] = in_tri.vert_a_z;
  assign vb[0] = in_tri.vert_b_x;
  assign vb[1] = in_tri.vert_b_y;
  assign vb[2] = in_tri.vert_b_z;
  assign vc[0] = in_tri.vert_c_x;
  assign vc[1] = in_tri.vert_c_y;
  assign vc[2] = in_tri.vert_c_z;

  // datapath registers, numbered by stage
  logic signed [EW-1:0]   e1_r1 [3], e2_r1 [3], o_r1 [3];
  logic signed [EW-1:0]   e1_r2 [3], e2_r2 [3], o_r2 [3];
  logic signed [EW-1:0]   e1_r3 [3], e2_r3 [3], o_r3 [3];
  logic signed [PMW-1:0]  pma_r2 [3], pmb_r2 [3];
  logic signed [PNW-1:0]  pna_r2 [3], pnb_r2 [3];
  logic signed [MW-1:0]   m_r3 [3];
  logic signed [NW-1:0]   n_r3 [3];
  logic signed [PDLW-1:0] dl_r4 [3], bl_r4 [3];
  logic signed [PDHW-1:0] dh_r4 [3], bh_r4 [3];
  logic signed [PNLW-1:0] tl_r4 [3];
  logic signed [PNHW-1:0] th_r4 [3];
  logic signed [PGLW-1:0] gl_r4 [3];
  logic signed [PGHW-1:0] gh_r4 [3];
  logic signed [DW-1:0]   dt_r5 [3], bt_r5 [3], gt_r5 [3];
  logic signed [TW-1:0]   tt_r5 [3];
  logic signed [DW-1:0]   det_r6, nb_r6, ng_r6;
  logic signed [TW-1:0]   nt_r6;
  logic signed [PDW-1:0]  pdet_r7, png_r7, pnb_r7;
  logic signed [PTW-1:0]  pnt_r7;
  logic                   par_r7;
  logic signed [PDW-1:0]  pdet_r8;
  logic signed [PTW-1:0]  pnt_r8;
  logic signed [PDW:0]    nbg_r8;
  logic signed [MLW-1:0]  mlo_r8;
  logic signed [MHW-1:0]  mhi_r8;
  logic                   par_r8, gam_r8, nbn_r8;
  logic signed [PDW-1:0]  pdet_r9;
  logic signed [PTW-1:0]  pnt_r9;
  logic signed [RW-1:0]   mdet_r9;
  logic                   par_r9, gam_r9, bet_r9;
  logic [RW-1:0]          lhs_r10;
  logic [PDW-1:0]         det_r10;
  logic [REASON_W-1:0]    reason_r10;
  logic                   sat_r10;

  // parallel test and distance checks, combinational ahead of stages 7 and 10
  logic [EPW-1:0]         adet6;
  logic [EPW-1:0]         eps_lim;
  logic signed [RW-1:0]   lhs9;
  logic                   near9;
  logic                   sat9;
  logic [REASON_W-1:0]    reason9;

  always_comb begin
    adet6   = det_r6[DW-1] ? EPW'(-PDW'(det_r6)) : EPW'(PDW'(det_r6));
    eps_lim = EPW'(eps_r) << (2 * FRAC_BITS);
    lhs9    = RW'(pnt_r9) <<< FRAC_BITS;
    near9   = (lhs9 < mdet_r9);
    sat9    = (lhs9 >= (RW'(pdet_r9) <<< DIST_W));
    if (par_r9) begin
      reason9 = MISS_PARALLEL;
    end else if (near9) begin
      reason9 = MISS_NEAR;
    end else if (gam_r9) begin
      reason9 = MISS_GAMMA;
    end else if (bet_r9) begin
      reason9 = MISS_BETA;
    end else begin
      reason9 = MISS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // stage 1: edges and offset from the ray origin
        e1_r1[i] <= EW'(va[i]) - EW'(vb[i]);
        e2_r1[i] <= EW'(va[i]) - EW'(vc[i]);
        o_r1[i]  <= EW'(va[i]) - EW'(origin_r[i]);
        e1_r2[i] <= e1_r1[i];
        e2_r2[i] <= e2_r1[i];
        o_r2[i]  <= o_r1[i];
        e1_r3[i] <= e1_r2[i];
        e2_r3[i] <= e2_r2[i];
        o_r3[i]  <= o_r2[i];
        // stage 3: cross products
        m_r3[i] <= MW'(pma_r2[i]) - MW'(pmb_r2[i]);
        n_r3[i] <= NW'(pna_r2[i]) - NW'(pnb_r2[i]);
        // stage 4: split products for the four dot products
        dl_r4[i] <= PDLW'(e1_r3[i]) * PDLW'($signed({1'b0, m_r3[i][ML-1:0]}));
        dh_r4[i] <= PDHW'(e1_r3[i]) * PDHW'($signed(m_r3[i][MW-1:ML]));
        bl_r4[i] <= PDLW'(o_r3[i]) * PDLW'($signed({1'b0, m_r3[i][ML-1:0]}));
        bh_r4[i] <= PDHW'(o_r3[i]) * PDHW'($signed(m_r3[i][MW-1:ML]));
        tl_r4[i] <= PNLW'(e2_r3[2-i]) * PNLW'($signed({1'b0, n_r3[i][NL-1:0]}));
        th_r4[i] <= PNHW'(e2_r3[2-i]) * PNHW'($signed(n_r3[i][NW-1:NL]));
        gl_r4[i] <= PGLW'(dir_r[2-i]) * PGLW'($signed({1'b0, n_r3[i][NL-1:0]}));
        gh_r4[i] <= PGHW'(dir_r[2-i]) * PGHW'($signed(n_r3[i][NW-1:NL]));
        // stage 5: reassemble each term
        dt_r5[i] <= (DW'(dh_r4[i]) <<< ML) + DW'(dl_r4[i]);
        bt_r5[i] <= (DW'(bh_r4[i]) <<< ML) + DW'(bl_r4[i]);
        tt_r5[i] <= (TW'(th_r4[i]) <<< NL) + TW'(tl_r4[i]);
        gt_r5[i] <= (DW'(gh_r4[i]) <<< NL) + DW'(gl_r4[i]);
      end
      // stage 2: edge-by-direction and edge-by-offset products
      pma_r2[0] <= PMW'(e2_r1[1]) * PMW'(dir_r[2]);
      pmb_r2[0] <= PMW'(dir_r[1]) * PMW'(e2_r1[2]);
      pma_r2[1] <= PMW'(dir_r[0]) * PMW'(e2_r1[2]);
      pmb_r2[1] <= PMW'(e2_r1[0]) * PMW'(dir_r[2]);
      pma_r2[2] <= PMW'(e2_r1[0]) * PMW'(dir_r[1]);
      pmb_r2[2] <= PMW'(e2_r1[1]) * PMW'(dir_r[0]);
      pna_r2[0] <= PNW'(e1_r1[0]) * PNW'(o_r1[1]);
      pnb_r2[0] <= PNW'(o_r1[0]) * PNW'(e1_r1[1]);
      pna_r2[1] <= PNW'(o_r1[0]) * PNW'(e1_r1[2]);
      pnb_r2[1] <= PNW'(e1_r1[0]) * PNW'(o_r1[2]);
      pna_r2[2] <= PNW'(e1_r1[1]) * PNW'(o_r1[2]);
      pnb_r2[2] <= PNW'(o_r1[1]) * PNW'(e1_r1[2]);
      // stage 6: determinant and numerators
      det_r6 <= dt_r5[0] + dt_r5[1] + dt_r5[2];
      nb_r6  <= bt_r5[0] + bt_r5[1] + bt_r5[2];
      ng_r6  <= gt_r5[0] + gt_r5[1] + gt_r5[2];
      nt_r6  <= -(tt_r5[0] + tt_r5[1] + tt_r5[2]);
      // stage 7: parallel test, and flip signs so the determinant is not negative
      par_r7 <= (det_r6 == '0) || (adet6 < eps_lim);
      if (det_r6[DW-1]) begin
        pdet_r7 <= -PDW'(det_r6);
        pnt_r7  <= -PTW'(nt_r6);
        png_r7  <= -PDW'(ng_r6);
        pnb_r7  <= -PDW'(nb_r6);
      end else begin
        pdet_r7 <= PDW'(det_r6);
        pnt_r7  <= PTW'(nt_r6);
        png_r7  <= PDW'(ng_r6);
        pnb_r7  <= PDW'(nb_r6);
      end
      // stage 8: gamma range, beta sum, min-distance product halves
      gam_r8  <= (png_r7 < 0) || (png_r7 > pdet_r7);
      nbn_r8  <= (pnb_r7 < 0);
      nbg_r8  <= (PDW+1)'(pnb_r7) + (PDW+1)'(png_r7);
      mlo_r8  <= MLW'($signed({1'b0, mind_r})) * MLW'($signed({1'b0, pdet_r7[DL-1:0]}));
      mhi_r8  <= MHW'($signed({1'b0, mind_r})) * MHW'($signed(pdet_r7[PDW-1:DL]));
      par_r8  <= par_r7;
      pdet_r8 <= pdet_r7;
      pnt_r8  <= pnt_r7;
      // stage 9: beta range, min-distance bound
      bet_r9  <= nbn_r8 || (nbg_r8 > (PDW+1)'(pdet_r8));
      mdet_r9 <= (RW'(mhi_r8) <<< DL) + RW'(mlo_r8);
      par_r9  <= par_r8;
      gam_r9  <= gam_r8;
      pdet_r9 <= pdet_r8;
      pnt_r9  <= pnt_r8;
      // stage 10: verdict and divider operands
      reason_r10 <= reason9;
      sat_r10    <= sat9;
      lhs_r10    <= lhs9;
      det_r10    <= pdet_r9;
    end
  end

  rti_meta_t          div_in_meta;
  rti_meta_t          div_out_meta;
  logic [DIST_W-1:0]  div_quo;

  assign div_in_meta.valid  = v_r[NSTG];
  assign div_in_meta.reason = reason_r10;
  assign div_in_meta.sat    = sat_r10;

  rti_div #(.RW(RW), .DW(PDW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_meta  (div_in_meta),
    .in_lhs   (lhs_r10),
    .in_det   (det_r10),
    .out_meta (div_out_meta),
    .out_quo  (div_quo)
  );

  // output register
  logic                hit_r;
  logic [DIST_W-1:0]   dist_r;
  logic [REASON_W-1:0] reason_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_out_meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r    <= (div_out_meta.reason == MISS_NONE);
      reason_r <= div_out_meta.reason;
      if (div_out_meta.reason != MISS_NONE) begin
        dist_r <= '0;
      end else if (div_out_meta.sat) begin
        dist_r <= DIST_MAX;
      end else begin
        dist_r <= div_quo;
      end
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.hit          = hit_r;
  assign out_res.hit_distance = dist_r;
  assign out_res.miss_reason  = reason_r;

endmodule

@@ rtl/rti_checker.sv @@
// Port-level checks on the intersection core, bound to the top level.
module rti_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic [rti_pkg::DIST_W-1:0]    out_dist,
  input logic [rti_pkg::REASON_W-1:0]  out_reason
);
  import rti_pkg::*;

  // a held result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_reason == MISS_NONE)))
    else $error("hit flag disagrees with miss reason");

  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_dist == '0))
    else $error("nonzero distance on a miss");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_hit    (out_res.hit),
  .out_dist   (out_res.hit_distance),
  .out_reason (out_res.miss_reason)
);
